[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on the rising edge and
// disabled while the asynchronous reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ILS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define ILS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/ils_pkg.sv]
// ---------------------------------------------------------------------------
// ils_pkg
// Types, codes and helper functions shared by the inverse Legendre
// synthesis controller, datapath and top level.
// ---------------------------------------------------------------------------
package ils_pkg;

	// Field and register widths
	localparam int IDX_W      = 10;
	localparam int FLD_W      = 2;
	localparam int VAL_W      = 32;
	localparam int WN_W       = 6;
	localparam int SUM_W      = 48;
	localparam int ACC_W      = 64;
	localparam int DEG_W      = 5;
	localparam int FCNT_W     = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 6;
	localparam int OFS_W      = 11;

	// Input opcodes
	localparam logic [1:0] OP_SPEC    = 2'd0;
	localparam logic [1:0] OP_LEG     = 2'd1;
	localparam logic [1:0] OP_COMPUTE = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TRUNC  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FTRUNC = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LTRUNC = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FCOUNT = 3'd3;

	// Rounding of Q12.50 products to Q16.31; m > 0 keeps one more bit (doubling)
	localparam logic signed [ACC_W-1:0] ROUND_M0 = 64'sh40000;
	localparam logic signed [ACC_W-1:0] ROUND_MN = 64'sh20000;
	localparam int SHIFT_M0 = 19;
	localparam int SHIFT_MN = 18;

	localparam logic signed [ACC_W-1:0] SUM_MAX = 64'sh00007FFFFFFFFFFF;
	localparam logic signed [ACC_W-1:0] SUM_MIN = -64'sh0000800000000000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OFFSET,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} ils_state_t;

	// Effective configuration, clamps already applied
	typedef struct packed {
		logic [DEG_W-1:0]  t_eff;
		logic [DEG_W-1:0]  lp_eff;
		logic [WN_W-1:0]   ft;
		logic [FCNT_W-1:0] fields;
	} ils_cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic load_req;
		logic calc_offset;
		logic issue;
		logic load_out;
	} ils_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic req_compute;
		logic run_needed;
		logic last_issue;
		logic rd_pending;
		logic mul_pending;
		logic out_free;
	} ils_sts_t;

	// Start of row m in a triangle of degree t (m <= t)
	function automatic logic [OFS_W-1:0] tri_offset(input logic [DEG_W-1:0] m,
			input logic [DEG_W-1:0] t);
		logic [OFS_W-1:0] lin;
		logic [OFS_W-1:0] tri_part;
		lin      = OFS_W'(m) * (OFS_W'(t) + OFS_W'(1));
		tri_part = (OFS_W'(m) * (OFS_W'(m) - OFS_W'(1))) >> 1;
		return lin - tri_part;
	endfunction

	function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [ACC_W-1:0] v);
		if (v > SUM_MAX)
			return SUM_MAX[SUM_W-1:0];
		else if (v < SUM_MIN)
			return SUM_MIN[SUM_W-1:0];
		else
			return v[SUM_W-1:0];
	endfunction

endpackage

[hdl/ils_ctrl.sv]
// ---------------------------------------------------------------------------
// ils_ctrl
// Sequencer for the synthesis block: takes input items, steps the datapath
// through offset calculation, the multiply-accumulate walk, pipeline drain
// and result hand-off.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ils_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ils_pkg::ils_sts_t sts,
	output ils_pkg::ils_cmd_t cmd
);
	import ils_pkg::*;

	ils_state_t state_q;
	ils_state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d         = state_q;
		cmd             = '0;
		in_stall        = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
				if (in_valid && sts.req_compute) begin
					cmd.load_req = 1'b1;
					state_d      = ST_OFFSET;
				end
			end
			ST_OFFSET: begin
				cmd.calc_offset = 1'b1;
				state_d         = sts.run_needed ? ST_RUN : ST_FINISH;
			end
			ST_RUN: begin
				cmd.issue = 1'b1;
				if (sts.last_issue)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				// last product accumulates on the edge that leaves this state
				if (!sts.rd_pending)
					state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`ILS_ASSERT_IMPL(a_finish_drained, clk, arst_n, state_q == ST_FINISH, !sts.rd_pending && !sts.mul_pending, "result stage reached with products in flight")
	`ILS_ASSERT_NEXT(a_issue_fills, clk, arst_n, cmd.issue, sts.rd_pending, "issued read did not reach the read stage")
	`ILS_ASSERT_IMPL(a_offset_after_req, clk, arst_n, state_q == ST_OFFSET, $past(cmd.load_req), "offset step without a captured request")

endmodule

[hdl/ils_datapath.sv]
// ---------------------------------------------------------------------------
// ils_datapath
// Coefficient and Legendre memories, request capture, triangle offset
// calculation, shared complex multiply-accumulate and output register.
// ---------------------------------------------------------------------------
module ils_datapath #(
	parameter int MAX_TRUNC  = 31,
	parameter int MAX_FIELDS = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ils_pkg::ils_cmd_t                  cmd,
	output ils_pkg::ils_sts_t                  sts,
	input  ils_pkg::ils_cfg_t                  cfg,
	input  logic [1:0]                         opcode,
	input  logic [ils_pkg::IDX_W-1:0]          table_index,
	input  logic [ils_pkg::FLD_W-1:0]          field_select,
	input  logic signed [ils_pkg::VAL_W-1:0]   value_real,
	input  logic signed [ils_pkg::VAL_W-1:0]   value_imag,
	input  logic [ils_pkg::WN_W-1:0]           wavenumber,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [ils_pkg::SUM_W-1:0]   real_sum,
	output logic signed [ils_pkg::SUM_W-1:0]   imag_sum,
	output logic [ils_pkg::FLD_W-1:0]          result_field,
	output logic [ils_pkg::WN_W-1:0]           result_wavenumber,
	output logic                               status
);
	import ils_pkg::*;

	localparam int TRI_DEPTH  = (MAX_TRUNC + 1) * (MAX_TRUNC + 2) / 2;
	localparam int SPEC_DEPTH = TRI_DEPTH * MAX_FIELDS;
	localparam int LEG_AW     = $clog2(TRI_DEPTH);
	localparam int SPEC_AW    = $clog2(SPEC_DEPTH);

	logic [2*VAL_W-1:0] spec_mem [SPEC_DEPTH];
	logic [VAL_W-1:0]   leg_mem  [TRI_DEPTH];

	logic               fld_ok;
	logic               idx_ok;
	logic [SPEC_AW-1:0] wr_spec_addr;
	logic [LEG_AW-1:0]  wr_leg_addr;
	logic [SPEC_AW-1:0] rd_spec_addr;

	logic [WN_W-1:0]    m_q;
	logic [FLD_W-1:0]   fld_q;
	logic               over_q;
	logic               run_q;
	logic               m_zero_q;
	logic [LEG_AW-1:0]  k_addr_q;
	logic [LEG_AW-1:0]  l_addr_q;
	logic [DEG_W-1:0]   remain_q;

	logic [2*VAL_W-1:0]       spec_rd_s1;
	logic signed [VAL_W-1:0]  leg_rd_s1;
	logic                     v_s1;
	logic signed [ACC_W-1:0]  prod_re_s2;
	logic signed [ACC_W-1:0]  prod_im_s2;
	logic                     v_s2;
	logic signed [ACC_W-1:0]  term_re;
	logic signed [ACC_W-1:0]  term_im;
	logic signed [ACC_W-1:0]  acc_re_q;
	logic signed [ACC_W-1:0]  acc_im_q;

	logic                     out_valid_q;
	logic signed [SUM_W-1:0]  real_sum_q;
	logic signed [SUM_W-1:0]  imag_sum_q;
	logic [FLD_W-1:0]         result_field_q;
	logic [WN_W-1:0]          result_wavenumber_q;
	logic                     status_q;

	// Input decode
	assign fld_ok       = {1'b0, field_select} < cfg.fields;
	assign idx_ok       = 32'(table_index) < TRI_DEPTH;
	assign wr_spec_addr = SPEC_AW'(32'(table_index) * MAX_FIELDS + 32'(field_select));
	assign wr_leg_addr  = LEG_AW'(table_index);
	assign rd_spec_addr = SPEC_AW'(32'(k_addr_q) * MAX_FIELDS + 32'(fld_q));

	// Coefficient memory: imaginary in the high half
	always_ff @(posedge clk) begin
		if (cmd.accept && opcode == OP_SPEC && fld_ok && idx_ok)
			spec_mem[wr_spec_addr] <= {value_imag, value_real};
		if (cmd.issue)
			spec_rd_s1 <= spec_mem[rd_spec_addr];
	end

	// Legendre memory
	always_ff @(posedge clk) begin
		if (cmd.accept && opcode == OP_LEG && idx_ok)
			leg_mem[wr_leg_addr] <= value_real;
		if (cmd.issue)
			leg_rd_s1 <= leg_mem[l_addr_q];
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			m_q      <= wavenumber;
			fld_q    <= field_select;
			over_q   <= wavenumber > cfg.ft;
			run_q    <= !(wavenumber > cfg.ft) && fld_ok && (wavenumber <= WN_W'(cfg.t_eff));
			m_zero_q <= wavenumber == '0;
		end
	end

	// Row offsets and walk counters
	always_ff @(posedge clk) begin
		if (cmd.calc_offset) begin
			k_addr_q <= LEG_AW'(tri_offset(DEG_W'(m_q), cfg.t_eff));
			l_addr_q <= LEG_AW'(tri_offset(DEG_W'(m_q), cfg.lp_eff));
			remain_q <= cfg.t_eff - DEG_W'(m_q);
		end else if (cmd.issue) begin
			k_addr_q <= k_addr_q + LEG_AW'(1);
			l_addr_q <= l_addr_q + LEG_AW'(1);
			remain_q <= remain_q - DEG_W'(1);
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	// Multiply stage
	always_ff @(posedge clk) begin
		if (v_s1) begin
			prod_re_s2 <= $signed(spec_rd_s1[VAL_W-1:0]) * leg_rd_s1;
			prod_im_s2 <= $signed(spec_rd_s1[2*VAL_W-1:VAL_W]) * leg_rd_s1;
		end
	end

	// Round to Q16.31 (one bit less shift when m > 0 doubles the term)
	always_comb begin
		if (m_zero_q) begin
			term_re = (prod_re_s2 + ROUND_M0) >>> SHIFT_M0;
			term_im = (prod_im_s2 + ROUND_M0) >>> SHIFT_M0;
		end else begin
			term_re = (prod_re_s2 + ROUND_MN) >>> SHIFT_MN;
			term_im = (prod_im_s2 + ROUND_MN) >>> SHIFT_MN;
		end
	end

	// Accumulators
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (v_s2) begin
			acc_re_q <= acc_re_q + term_re;
			acc_im_q <= acc_im_q + term_im;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			real_sum_q          <= sat_sum(acc_re_q);
			imag_sum_q          <= sat_sum(acc_im_q);
			result_field_q      <= fld_q;
			result_wavenumber_q <= m_q;
			status_q            <= over_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign real_sum          = real_sum_q;
	assign imag_sum          = imag_sum_q;
	assign result_field      = result_field_q;
	assign result_wavenumber = result_wavenumber_q;
	assign status            = status_q;

	// Status to the controller
	always_comb begin
		sts.req_compute = opcode == OP_COMPUTE;
		sts.run_needed  = run_q;
		sts.last_issue  = remain_q == '0;
		sts.rd_pending  = v_s1;
		sts.mul_pending = v_s2;
		sts.out_free    = !out_valid_q || !out_stall;
	end

endmodule

[hdl/inverse_legendre_synthesis_top.sv]
// ---------------------------------------------------------------------------
// inverse_legendre_synthesis_top
// Inverse Legendre synthesis for one latitude: coefficient and Legendre
// loading, per-wavenumber complex multiply-accumulate, saturated Q16.31 sums.
// ---------------------------------------------------------------------------
// Write items (spectral pair, Legendre value) and ignored opcodes are accepted
// directly in the idle state. A compute item for wavenumber m with truncation
// T occupies the block through these steps: accept, the two triangle offsets,
// one step per degree m..T through the single shared complex
// multiply-accumulate (one read of each memory per cycle), a drain of the
// read and multiply stages, and the load of the output register, which waits
// while a held result is stalled. A compute that needs no sum (m above T or
// above the Fourier truncation, or an unused field) skips the walk and drain.
// The output register lets the next item be accepted while a result waits.
// Configuration writes are always ready and must be made while idle.
// ---------------------------------------------------------------------------
module inverse_legendre_synthesis_top #(
	parameter int MAX_TRUNC  = 31,
	parameter int MAX_FIELDS = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Input items
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           opcode,
	input  logic [ils_pkg::IDX_W-1:0]            table_index,
	input  logic [ils_pkg::FLD_W-1:0]            field_select,
	input  logic signed [ils_pkg::VAL_W-1:0]     value_real,
	input  logic signed [ils_pkg::VAL_W-1:0]     value_imag,
	input  logic [ils_pkg::WN_W-1:0]             wavenumber,
	// Results
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [ils_pkg::SUM_W-1:0]     real_sum,
	output logic signed [ils_pkg::SUM_W-1:0]     imag_sum,
	output logic [ils_pkg::FLD_W-1:0]            result_field,
	output logic [ils_pkg::WN_W-1:0]             result_wavenumber,
	output logic                                 status,
	// Configuration writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ils_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ils_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import ils_pkg::*;

	logic [DEG_W-1:0]  trunc_q;
	logic [WN_W-1:0]   ftrunc_q;
	logic [DEG_W-1:0]  ltrunc_q;
	logic [FCNT_W-1:0] fcount_q;

	logic [DEG_W-1:0]  t_clamp;
	logic [DEG_W-1:0]  l_clamp;
	logic [FCNT_W-1:0] f_clamp;
	ils_cfg_t          cfg;
	ils_cmd_t          cmd;
	ils_sts_t          sts;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trunc_q  <= 5'd31;
			ftrunc_q <= 6'd31;
			ltrunc_q <= 5'd31;
			fcount_q <= 3'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TRUNC:  trunc_q  <= cfg_data[DEG_W-1:0];
				CFG_FTRUNC: ftrunc_q <= cfg_data[WN_W-1:0];
				CFG_LTRUNC: ltrunc_q <= cfg_data[DEG_W-1:0];
				CFG_FCOUNT: fcount_q <= cfg_data[FCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective settings: clamp to the build limits, Legendre degree >= T,
	// field count of zero acts as one
	always_comb begin
		t_clamp = (32'(trunc_q) > MAX_TRUNC) ? DEG_W'(MAX_TRUNC) : trunc_q;
		l_clamp = (32'(ltrunc_q) > MAX_TRUNC) ? DEG_W'(MAX_TRUNC) : ltrunc_q;
		f_clamp = (32'(fcount_q) > MAX_FIELDS) ? FCNT_W'(MAX_FIELDS) : fcount_q;
		cfg.t_eff  = t_clamp;
		cfg.lp_eff = (l_clamp < t_clamp) ? t_clamp : l_clamp;
		cfg.ft     = ftrunc_q;
		cfg.fields = (fcount_q == '0) ? FCNT_W'(1) : f_clamp;
	end

	ils_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ils_datapath #(
		.MAX_TRUNC  (MAX_TRUNC),
		.MAX_FIELDS (MAX_FIELDS)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.cfg               (cfg),
		.opcode            (opcode),
		.table_index       (table_index),
		.field_select      (field_select),
		.value_real        (value_real),
		.value_imag        (value_imag),
		.wavenumber        (wavenumber),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.real_sum          (real_sum),
		.imag_sum          (imag_sum),
		.result_field      (result_field),
		.result_wavenumber (result_wavenumber),
		.status            (status)
	);

endmodule
